/* src/slins_pkg.sv */
// Package with the shared types and constants of the sorted list insert block.
package slins_pkg;

  localparam int unsigned CapacityDef = 16;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 4;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_INDEX = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic write_cells;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic full;
  } dp_status_t;

endpackage

/* src/sorted_list_insert.sv */
// Top level of the sorted list insert block.
// Keeps up to CAPACITY signed 32-bit values in ascending order in a row of
// compare-and-shift cells; an insert places the new value ahead of every
// stored value that is greater than or equal to it, and a read returns the
// entry at a position. A command word is captured in S_IDLE; in S_EXEC, once
// the result register is empty or being read, every cell compares against the
// new value in parallel, the row shifts, and the result register is loaded.
// No word is taken in S_EXEC. A finished result waits in that register while
// the next word is already captured. Every result word carries the entry count
// after the command, and only positions up to fifteen are reachable by a read.
module sorted_list_insert
  import slins_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // value[31:0], position[35:32], zero fill
  input  logic                s_axis_tuser_i,   // cmd
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o    // status[1:0], read_value[33:2],
                                                // count[38:34], zero fill
);

  ctrl_cmd_t                ctrl_cmd;
  dp_status_t               dp_status;
  logic        [StatusW-1:0] out_status;
  logic signed [ValueW-1:0]  out_value;
  logic        [CountW-1:0]  out_count;

  slins_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .dp_status_i (dp_status),
    .ctrl_cmd_o  (ctrl_cmd)
  );

  slins_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_cmd_i     (s_axis_tuser_i),
    .in_value_i   (s_axis_tdata_i[ValueW-1:0]),
    .in_pos_i     (s_axis_tdata_i[ValueW+PosW-1:ValueW]),
    .ctrl_cmd_i   (ctrl_cmd),
    .dp_status_o  (dp_status),
    .out_status_o (out_status),
    .out_value_o  (out_value),
    .out_count_o  (out_count)
  );

  assign m_axis_tdata_o = {{(OutDataW - StatusW - ValueW - CountW){1'b0}},
                           out_count, out_value, out_status};

endmodule

/* src/slins_ctrl.sv */
// Controller state machine of the sorted list insert block.
module slins_ctrl
  import slins_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t dp_status_i,
  output ctrl_cmd_t  ctrl_cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;
    ctrl_cmd_o  = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o         = 1'b1;
        ctrl_cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_cmd_o.exec        = 1'b1;
          ctrl_cmd_o.write_cells = dp_status_i.is_insert & ~dp_status_i.full;
          out_valid_d            = 1'b1;
          state_d                = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/slins_dp.sv */
// Datapath of the sorted list insert block: command register, cell array and result register.
module slins_dp
  import slins_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_cmd_i,
  input  logic signed [ValueW-1:0]  in_value_i,
  input  logic        [PosW-1:0]    in_pos_i,
  input  ctrl_cmd_t                 ctrl_cmd_i,
  output dp_status_t                dp_status_o,
  output logic        [StatusW-1:0] out_status_o,
  output logic signed [ValueW-1:0]  out_value_o,
  output logic        [CountW-1:0]  out_count_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = CntW + PosW;
  localparam int unsigned RdN  = (CAPACITY < 16) ? CAPACITY : 16;

  logic                     cmd_q;
  logic signed [ValueW-1:0] value_q;
  logic        [PosW-1:0]   pos_q;

  logic signed [ValueW-1:0] cell_q [CAPACITY];
  logic        [CntW-1:0]   count_q, count_d;
  logic        [CAPACITY-1:0] ge;

  logic        [StatusW-1:0] status_d, out_status_q;
  logic signed [ValueW-1:0]  rd_mux, rd_d, out_value_q;
  logic        [CountW-1:0]  out_count_q;
  logic        [CntW+CountW-1:0] count_ext;
  logic                      full;
  logic                      pos_bad;

  always_ff @(posedge clk_i) begin
    if (ctrl_cmd_i.load_in) begin
      cmd_q   <= in_cmd_i;
      value_q <= in_value_i;
      pos_q   <= in_pos_i;
    end
  end

  assign full    = (count_q == CntW'(CAPACITY));
  assign pos_bad = (CmpW'(pos_q) >= CmpW'(count_q));

  assign dp_status_o.is_insert = (cmd_q == CMD_INSERT);
  assign dp_status_o.full      = full;

  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      ge[k] = (CntW'(k) < count_q) && (cell_q[k] >= value_q);
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    if (k == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (ctrl_cmd_i.write_cells && (ge[0] || count_q == '0)) begin
          cell_q[0] <= value_q;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk_i) begin
        if (ctrl_cmd_i.write_cells) begin
          if (ge[k-1]) begin
            cell_q[k] <= cell_q[k-1];
          end else if (ge[k] || count_q == CntW'(k)) begin
            cell_q[k] <= value_q;
          end
        end
      end
    end
  end

  always_comb begin
    rd_mux = '0;
    for (int k = 0; k < RdN; k++) begin
      if (pos_q == PosW'(k)) begin
        rd_mux = cell_q[k];
      end
    end
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    rd_d     = '0;
    if (cmd_q == CMD_INSERT) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (pos_bad) begin
        status_d = ST_INDEX;
      end else begin
        rd_d = rd_mux;
      end
    end
  end

  assign count_ext = (CntW + CountW)'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_cmd_i.exec) begin
      out_status_q <= status_d;
      out_value_q  <= rd_d;
      out_count_q  <= count_ext[CountW-1:0];
    end
  end

  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;
  assign out_count_o  = out_count_q;

endmodule

/* src/slins_check.sv */
// Port-level checker of the sorted list insert block and its bind statement.
module slins_check
  import slins_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_tvalid_i,
  input logic                s_tready_i,
  input logic                m_tvalid_i,
  input logic                m_tready_i,
  input logic [OutDataW-1:0] m_tdata_i
);

  logic [StatusW-1:0] status;
  logic [ValueW-1:0]  rd_value;
  logic [CountW-1:0]  count;
  logic [31:0]        cap;

  assign status   = m_tdata_i[StatusW-1:0];
  assign rd_value = m_tdata_i[StatusW+ValueW-1:StatusW];
  assign count    = m_tdata_i[StatusW+ValueW+CountW-1:StatusW+ValueW];
  assign cap      = 32'(CAPACITY);

  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_i) |=> !s_tready_i)
    else $error("input accepted a word while the previous one was executing");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && status != ST_OK) |-> (rd_value == '0))
    else $error("refused command returned a nonzero value");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && status == ST_FULL) |-> (count == cap[CountW-1:0]))
    else $error("full status with a count below capacity");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (CAPACITY > 31 || 32'(count) <= cap))
    else $error("count exceeds capacity");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && !m_tready_i) |=> (m_tvalid_i && $stable(m_tdata_i)))
    else $error("stalled result word changed");

endmodule

bind sorted_list_insert slins_check #(
  .CAPACITY (CAPACITY)
) u_slins_check (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);
